### sv/smt_pkg.sv
package smt_pkg;

	localparam int IndexBits   = 10;
	localparam int InBits      = IndexBits + 5 * 16;
	localparam int InDataBits  = ((InBits + 7) / 8) * 8;
	localparam int OutBits     = IndexBits + 17 + 15 + 21 + 21;
	localparam int OutDataBits = ((OutBits + 7) / 8) * 8;

	// row error limit, 2 px in Q12.4
	localparam logic signed [16:0] RowLimit = 17'sd32;
	localparam logic [14:0] DepthMax = 15'h7fff;
	localparam logic [20:0] CamMag  = 21'h100000;
	localparam logic [20:0] CamPos  = 21'h0fffff;

	localparam int DepSteps = 15;
	localparam int CamSteps = 20;
	localparam int SCap  = 1;
	localparam int SMul  = 2;
	localparam int SChk  = 3;
	localparam int SDdiv = 4;
	localparam int SDep  = SDdiv + DepSteps;
	localparam int SCmul = SDep + 1;
	localparam int SCadd = SCmul + 1;
	localparam int SCdiv = SCadd + 1;
	localparam int SOut  = SCdiv + CamSteps;
	localparam int NStages = SOut;

	typedef enum logic [2:0] {
		REJ_NONE  = 3'd0,
		REJ_TRACK = 3'd1,
		REJ_ROW   = 3'd2,
		REJ_DISP  = 3'd3,
		REJ_ERR   = 3'd4,
		REJ_DEPTH = 3'd5
	} rej_t;

	typedef enum logic [2:0] {
		CFG_FOCAL_X  = 3'd0,
		CFG_FOCAL_Y  = 3'd1,
		CFG_CENTER_X = 3'd2,
		CFG_CENTER_Y = 3'd3,
		CFG_BASELINE = 3'd4,
		CFG_MIN_DEP  = 3'd5,
		CFG_MAX_DEP  = 3'd6,
		CFG_MAX_ERR  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [IndexBits-1:0] idx;
		logic                 ok;
		logic                 row_bad;
		logic [15:0]          err;
		logic signed [16:0]   disp;
		logic signed [17:0]   ox;
		logic signed [17:0]   oy;
		logic [30:0]          dmax;
		logic [30:0]          dmin;
		rej_t                 code;
		logic [37:0]          rem1;
		logic [21:0]          den1;
		logic                 ov1;
		logic [14:0]          q1;
		logic [14:0]          dep;
		logic [16:0]          magx;
		logic [16:0]          magy;
		logic                 negx;
		logic                 negy;
		logic [31:0]          mx;
		logic [31:0]          my;
		logic [36:0]          remx;
		logic [36:0]          remy;
		logic                 ovx;
		logic                 ovy;
		logic [19:0]          qx;
		logic [19:0]          qy;
		logic signed [20:0]   camx;
		logic signed [20:0]   camy;
	} item_t;

endpackage

### sv/stereo_match_triangulate_top.sv
// Stereo correspondence check and triangulation. One correspondence per cycle
// enters on the s_axis side while the output is not stalled, and one result
// per correspondence leaves on the m_axis side, in order. The pipeline
// depth is dominated by two pipelined restoring dividers: 15 stages for
// depth = fx*baseline/(64*disparity) and 20 stages for camera X and Y.
// Every stage advances together; a stalled output holds the whole pipeline.
// Checks in order: track flag, row error above 2 px, disparity bounds from
// the depth limits, match error, depth range. Configuration is to be written on
// the cfg port only while no transaction is in flight; the block does not enforce it.
module stereo_match_triangulate_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// point_index, left_x, left_y, right_x, right_y, match_error, zero pad
	input  logic [smt_pkg::InDataBits-1:0]   s_axis_tdata,
	// track_ok
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_index, disparity, depth, cam_x, cam_y, zero pad
	output logic [smt_pkg::OutDataBits-1:0]  m_axis_tdata,
	// accepted, reject_code
	output logic [3:0]                       m_axis_tuser
);
	import smt_pkg::*;

	localparam int Ib = IndexBits;

	// configuration registers
	logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q, baseline_q, max_err_q;
	logic [14:0] min_dep_q, max_dep_q;
	// focal_x * baseline, refreshed every cycle from the registers
	logic [31:0] p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 16'd8000;
			focal_y_q  <= 16'd8000;
			center_x_q <= 16'd5120;
			center_y_q <= 16'd3840;
			baseline_q <= 16'd7864;
			min_dep_q  <= 15'd256;
			max_dep_q  <= 15'd30720;
			max_err_q  <= 16'd5120;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FOCAL_X:  focal_x_q  <= cfg_data;
				CFG_FOCAL_Y:  focal_y_q  <= cfg_data;
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_BASELINE: baseline_q <= cfg_data;
				CFG_MIN_DEP:  min_dep_q  <= cfg_data[14:0];
				CFG_MAX_DEP:  max_dep_q  <= cfg_data[14:0];
				CFG_MAX_ERR:  max_err_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= {16'd0, focal_x_q} * {16'd0, baseline_q};
	end

	// pipeline: stage k lives in pipe_s[k], its valid in vld_s[k]
	item_t pipe_s [1:NStages];
	item_t nxt    [1:NStages];
	logic  vld_s  [1:NStages];
	logic  en;

	// the whole pipe moves unless the output holds a result not yet taken
	assign en            = !vld_s[NStages] || m_axis_tready;
	assign s_axis_tready = en;

	// capture stage: unpack, disparity, row error, offsets from the center
	always_comb begin
		logic signed [15:0] lx, ly, rx, ry;
		logic signed [16:0] dy;
		lx = s_axis_tdata[Ib +: 16];
		ly = s_axis_tdata[Ib+16 +: 16];
		rx = s_axis_tdata[Ib+32 +: 16];
		ry = s_axis_tdata[Ib+48 +: 16];
		nxt[SCap]         = '0;
		nxt[SCap].idx     = s_axis_tdata[Ib-1:0];
		nxt[SCap].err     = s_axis_tdata[Ib+64 +: 16];
		nxt[SCap].ok      = s_axis_tuser[0];
		nxt[SCap].disp    = {lx[15], lx} - {rx[15], rx};
		dy                = {ly[15], ly} - {ry[15], ry};
		nxt[SCap].row_bad = (dy > RowLimit) || (dy < -RowLimit);
		nxt[SCap].ox      = {{2{lx[15]}}, lx} - $signed({2'b00, center_x_q});
		nxt[SCap].oy      = {{2{ly[15]}}, ly} - $signed({2'b00, center_y_q});
		nxt[SCap].code    = REJ_NONE;
	end

	for (genvar k = 2; k <= NStages; k++) begin : g_stage
		// quotient bit handled by this stage in each divider
		localparam int BitD = (k >= SDdiv && k < SDep) ? DepSteps - 1 - (k - SDdiv) : 0;
		localparam int BitC = (k >= SCdiv && k < SOut) ? CamSteps - 1 - (k - SCdiv) : 0;
		always_comb begin
			logic        dpos;
			logic [37:0] sh1;
			logic [36:0] shx, shy;
			logic [20:0] vx, vy;
			nxt[k] = pipe_s[k-1];
			dpos = !pipe_s[k-1].disp[16] && (pipe_s[k-1].disp != 17'sd0);
			sh1  = '0;
			shx  = '0;
			shy  = '0;
			vx   = '0;
			vy   = '0;
			if (k == SMul) begin
				// disparity bound products and the rounded depth numerator
				nxt[k].dmax = {15'd0, pipe_s[k-1].disp[15:0]} * {16'd0, max_dep_q};
				nxt[k].dmin = {15'd0, pipe_s[k-1].disp[15:0]} * {16'd0, min_dep_q};
				nxt[k].rem1 = {6'd0, p_q} + {17'd0, pipe_s[k-1].disp[15:0], 5'd0};
				nxt[k].den1 = {pipe_s[k-1].disp[15:0], 6'd0};
			end else if (k == SChk) begin
				// first failing check wins
				if (!pipe_s[k-1].ok)
					nxt[k].code = REJ_TRACK;
				else if (pipe_s[k-1].row_bad)
					nxt[k].code = REJ_ROW;
				else if (!dpos || {pipe_s[k-1].dmax, 6'd0} < {5'd0, p_q}
						|| {pipe_s[k-1].dmin, 6'd0} > {5'd0, p_q})
					nxt[k].code = REJ_DISP;
				else if (pipe_s[k-1].err > max_err_q)
					nxt[k].code = REJ_ERR;
				else
					nxt[k].code = REJ_NONE;
				// quotient would not fit in 15 bits
				nxt[k].ov1 = pipe_s[k-1].rem1 >= {1'b0, pipe_s[k-1].den1, 15'd0};
				nxt[k].q1  = '0;
			end else if (k >= SDdiv && k < SDep) begin
				// one depth quotient bit per stage, msb first
				sh1 = {16'd0, pipe_s[k-1].den1} << BitD;
				if (pipe_s[k-1].rem1 >= sh1) begin
					nxt[k].rem1 = pipe_s[k-1].rem1 - sh1;
					nxt[k].q1[BitD] = 1'b1;
				end
			end else if (k == SDep) begin
				if (pipe_s[k-1].code == REJ_NONE) begin
					nxt[k].dep = pipe_s[k-1].ov1 ? DepthMax : pipe_s[k-1].q1;
					if (nxt[k].dep < min_dep_q || nxt[k].dep > max_dep_q)
						nxt[k].code = REJ_DEPTH;
				end else begin
					nxt[k].dep = '0;
				end
				nxt[k].negx = pipe_s[k-1].ox[17];
				nxt[k].negy = pipe_s[k-1].oy[17];
				vx[17:0] = pipe_s[k-1].ox[17] ? -pipe_s[k-1].ox : pipe_s[k-1].ox;
				vy[17:0] = pipe_s[k-1].oy[17] ? -pipe_s[k-1].oy : pipe_s[k-1].oy;
				nxt[k].magx = vx[16:0];
				nxt[k].magy = vy[16:0];
			end else if (k == SCmul) begin
				nxt[k].mx = {15'd0, pipe_s[k-1].magx} * {17'd0, pipe_s[k-1].dep};
				nxt[k].my = {15'd0, pipe_s[k-1].magy} * {17'd0, pipe_s[k-1].dep};
			end else if (k == SCadd) begin
				// round half away: add half the focal length to the magnitude
				nxt[k].remx = {5'd0, pipe_s[k-1].mx} + {22'd0, focal_x_q[15:1]};
				nxt[k].remy = {5'd0, pipe_s[k-1].my} + {22'd0, focal_y_q[15:1]};
				nxt[k].ovx  = nxt[k].remx >= {1'b0, focal_x_q, 20'd0};
				nxt[k].ovy  = nxt[k].remy >= {1'b0, focal_y_q, 20'd0};
				nxt[k].qx   = '0;
				nxt[k].qy   = '0;
			end else if (k >= SCdiv && k < SOut) begin
				shx = {21'd0, focal_x_q} << BitC;
				shy = {21'd0, focal_y_q} << BitC;
				if (pipe_s[k-1].remx >= shx) begin
					nxt[k].remx = pipe_s[k-1].remx - shx;
					nxt[k].qx[BitC] = 1'b1;
				end
				if (pipe_s[k-1].remy >= shy) begin
					nxt[k].remy = pipe_s[k-1].remy - shy;
					nxt[k].qy[BitC] = 1'b1;
				end
			end else if (k == SOut) begin
				// saturate, apply sign, zero for early rejects and zero focal
				vx = pipe_s[k-1].ovx ? CamMag : {1'b0, pipe_s[k-1].qx};
				vy = pipe_s[k-1].ovy ? CamMag : {1'b0, pipe_s[k-1].qy};
				if (pipe_s[k-1].negx)
					nxt[k].camx = -$signed(vx);
				else
					nxt[k].camx = (vx > CamPos) ? $signed(CamPos) : $signed(vx);
				if (pipe_s[k-1].negy)
					nxt[k].camy = -$signed(vy);
				else
					nxt[k].camy = (vy > CamPos) ? $signed(CamPos) : $signed(vy);
				if ((pipe_s[k-1].code != REJ_NONE && pipe_s[k-1].code != REJ_DEPTH)
						|| focal_x_q == 16'd0)
					nxt[k].camx = '0;
				if ((pipe_s[k-1].code != REJ_NONE && pipe_s[k-1].code != REJ_DEPTH)
						|| focal_y_q == 16'd0)
					nxt[k].camy = '0;
			end
		end
	end

	for (genvar k = 1; k <= NStages; k++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= (k == 1) ? s_axis_tvalid : vld_s[(k == 1) ? 1 : k-1];
		end
		always_ff @(posedge clk) begin
			if (en)
				pipe_s[k] <= nxt[k];
		end
	end

	assign m_axis_tvalid = vld_s[NStages];
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[Ib-1:0]     = pipe_s[NStages].idx;
		m_axis_tdata[Ib +: 17]   = pipe_s[NStages].disp;
		m_axis_tdata[Ib+17 +: 15] = pipe_s[NStages].dep;
		m_axis_tdata[Ib+32 +: 21] = pipe_s[NStages].camx;
		m_axis_tdata[Ib+53 +: 21] = pipe_s[NStages].camy;
		m_axis_tuser[0]   = (pipe_s[NStages].code == REJ_NONE);
		m_axis_tuser[3:1] = pipe_s[NStages].code;
	end

endmodule
